// File: hdl/lrd_pkg.sv
package lrd_pkg;

  localparam int OFFSET_BITS = 48;
  localparam logic [31:0] CRC_POLY = 32'h82f6_3b78;
  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
  localparam logic [7:0] BATCH_RECORD_TYPE = 8'd1;
  localparam logic [3:0] HEADER_BYTES = 4'd9;
  localparam logic [3:0] BATCH_HEADER_BYTES = 4'd12;
  localparam logic [3:0] ENTRY_HEADER_BYTES = 4'd9;
  localparam int TDATA_FIELD_BITS = 172 + OFFSET_BITS;
  localparam int TDATA_BITS = ((TDATA_FIELD_BITS + 7) / 8) * 8;
  localparam int FIFO_DEPTH = 4;

  localparam logic [2:0] EV_START = 3'd0;
  localparam logic [2:0] EV_KEY = 3'd1;
  localparam logic [2:0] EV_VAL = 3'd2;
  localparam logic [2:0] EV_ACCEPT = 3'd3;
  localparam logic [2:0] EV_END = 3'd4;
  localparam logic [2:0] EV_CORRUPT = 3'd5;

  localparam logic [2:0] ERR_RECORD_TYPE = 3'd0;
  localparam logic [2:0] ERR_CHECKSUM = 3'd1;
  localparam logic [2:0] ERR_BATCH_HEADER = 3'd2;
  localparam logic [2:0] ERR_TRUNC_ENTRY = 3'd3;
  localparam logic [2:0] ERR_ENTRY_HEADER = 3'd4;
  localparam logic [2:0] ERR_TRUNC_PAYLOAD = 3'd5;
  localparam logic [2:0] ERR_ENTRY_TYPE = 3'd6;

  localparam logic REG_PUT_CODE = 1'b0;
  localparam logic REG_DELETE_CODE = 1'b1;

  typedef struct packed {
    logic [2:0]             event_res;
    logic [2:0]             error_code;
    logic                   entry_kind;
    logic [31:0]            key_length;
    logic [31:0]            value_length;
    logic [7:0]             byte_value;
    logic [63:0]            base_sequence;
    logic [31:0]            entry_count;
    logic [OFFSET_BITS-1:0] valid_bytes;
    logic                   last_of_run;
  } result_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic result_t mk_result(input logic [2:0] ev, input logic [2:0] err,
                                        input logic kind, input logic [31:0] klen,
                                        input logic [31:0] vlen, input logic [7:0] bval,
                                        input logic [63:0] seq, input logic [31:0] cnt,
                                        input logic [OFFSET_BITS-1:0] vb);
    result_t r;
    r.event_res = ev;
    r.error_code = err;
    r.entry_kind = kind;
    r.key_length = klen;
    r.value_length = vlen;
    r.byte_value = bval;
    r.base_sequence = seq;
    r.entry_count = cnt;
    r.valid_bytes = vb;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/log_record_decoder_top.sv
// Streaming parser for a CRC32C-framed write-ahead log.
// Input: one log byte per item on s_axis, s_axis_tlast marks the last byte of a log.
// Output: one event per item on m_axis; m_axis_tuser holds the event code and
// m_axis_tlast marks the final event caused by one input byte. Each byte causes
// zero to three events (entry start, key or value byte, accepted, log end, corruption).
// Configuration: cfg_we with cfg_index 0 writes the put code, index 1 the delete code.
// Events caused by a byte are written into the registered result queue when that byte is taken.
// Throughput: one byte per cycle while bytes cause at most one event each and the
// receiver does not stall; the four-entry result queue accepts a byte whenever it holds
// at most one event, so a byte causing two or three events holds off the next bytes.
// Reset (rst, synchronous) empties the queue, returns to the record header phase,
// clears the log position and restores the put and delete codes to 0 and 1.
// When the receiver stalls, events wait in the queue and s_axis_tready falls once
// the queue holds two or more events; nothing is lost.
module log_record_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // data_byte
  input  logic                           s_axis_tlast,  // end_of_log
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // error_code[2:0], entry_kind[3], key_length[35:4], value_length[67:36],
  // byte_value[75:68], base_sequence[139:76], entry_count[171:140],
  // valid_bytes[219:172], zero fill above
  output logic [lrd_pkg::TDATA_BITS-1:0] m_axis_tdata,
  output logic [2:0]                     m_axis_tuser,  // event_res
  output logic                           m_axis_tlast,  // last_of_run
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [7:0]                     cfg_data
);

  typedef enum logic [2:0] {PH_HDR, PH_BATCH, PH_ENTHDR, PH_KEY, PH_VAL, PH_TAIL, PH_DROP}
    phase_t;

  localparam int OB = lrd_pkg::OFFSET_BITS;
  localparam logic [OB-1:0] POS_MAX = {OB{1'b1}};

  logic [7:0]  put_code, delete_code;
  phase_t      phase, phase_next;
  logic [3:0]  fbc, fbc_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [31:0] payload_left, payload_left_next;
  logic [31:0] running_crc, running_crc_next;
  logic [63:0] sequence_base, sequence_base_next;
  logic [31:0] entries_total, entries_total_next;
  logic [31:0] entries_left, entries_left_next;
  logic [7:0]  kind_held, kind_held_next;
  logic [31:0] key_left, key_left_next;
  logic [31:0] value_left, value_left_next;
  logic        err_held, err_held_next;
  logic [2:0]  err_code, err_code_next;
  logic [OB-1:0] position, position_next;
  logic [OB-1:0] committed, committed_next;

  lrd_pkg::result_t res [3];
  logic [1:0]  nres;

  lrd_pkg::result_t fifo [lrd_pkg::FIFO_DEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        in_acc, out_acc;

  assign s_axis_tready = (count <= 3'd1);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != 3'd0);
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    logic [7:0]  b;
    logic        last, ended, vdo, ev_err_v, entry_end;
    logic [2:0]  ev_err;
    logic [1:0]  lo;
    logic [32:0] need;
    logic        kind;
    b = s_axis_tdata;
    last = s_axis_tlast;
    ended = 1'b0;
    vdo = 1'b0;
    ev_err_v = 1'b0;
    ev_err = lrd_pkg::ERR_RECORD_TYPE;
    entry_end = 1'b0;
    lo = fbc[1:0] - 2'd1;
    need = 33'd0;
    kind = 1'b0;
    phase_next = phase;
    fbc_next = fbc;
    stored_crc_next = stored_crc;
    record_kind_next = record_kind;
    payload_left_next = payload_left;
    running_crc_next = running_crc;
    sequence_base_next = sequence_base;
    entries_total_next = entries_total;
    entries_left_next = entries_left;
    kind_held_next = kind_held;
    key_left_next = key_left;
    value_left_next = value_left;
    err_held_next = err_held;
    err_code_next = err_code;
    committed_next = committed;
    position_next = (position != POS_MAX) ? position + 1'b1 : position;
    nres = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    if (phase == PH_DROP) begin
      ended = 1'b1;
    end else if (phase == PH_HDR) begin
      if (fbc == 4'd0) begin
        stored_crc_next = '0;
        payload_left_next = '0;
        record_kind_next = '0;
      end
      if (fbc < 4'd4) begin
        stored_crc_next[8*fbc[1:0] +: 8] = b;
      end else if (fbc < 4'd8) begin
        payload_left_next[8*fbc[1:0] +: 8] = b;
      end else begin
        record_kind_next = b;
      end
      fbc_next = fbc + 4'd1;
      if (fbc_next >= lrd_pkg::HEADER_BYTES) begin
        fbc_next = '0;
        running_crc_next = lrd_pkg::CRC_INIT;
        sequence_base_next = '0;
        entries_total_next = '0;
        entries_left_next = '0;
        err_held_next = 1'b0;
        phase_next = PH_BATCH;
        vdo = (payload_left_next == 32'd0);
      end
    end else begin
      running_crc_next = lrd_pkg::crc_step(running_crc, b);
      payload_left_next = payload_left - 32'd1;
      case (phase)
        PH_BATCH: begin
          if (fbc < 4'd8) sequence_base_next[8*fbc[2:0] +: 8] = b;
          else entries_total_next[8*fbc[1:0] +: 8] = b;
          fbc_next = fbc + 4'd1;
          if (fbc_next >= lrd_pkg::BATCH_HEADER_BYTES) begin
            fbc_next = '0;
            entries_left_next = entries_total_next;
            phase_next = (entries_total_next != 32'd0) ? PH_ENTHDR : PH_TAIL;
          end
        end
        PH_ENTHDR: begin
          if (fbc == 4'd0) begin
            kind_held_next = b;
            key_left_next = '0;
            value_left_next = '0;
          end else if (fbc < 4'd5) begin
            key_left_next[8*lo +: 8] = b;
          end else begin
            value_left_next[8*lo +: 8] = b;
          end
          fbc_next = fbc + 4'd1;
          if (fbc_next >= lrd_pkg::ENTRY_HEADER_BYTES) begin
            fbc_next = '0;
            need = {1'b0, key_left_next} + {1'b0, value_left_next};
            if (need > {1'b0, payload_left_next}) begin
              err_held_next = 1'b1;
              err_code_next = lrd_pkg::ERR_TRUNC_PAYLOAD;
              phase_next = PH_TAIL;
            end else if (kind_held_next != put_code && kind_held_next != delete_code) begin
              err_held_next = 1'b1;
              err_code_next = lrd_pkg::ERR_ENTRY_TYPE;
              phase_next = PH_TAIL;
            end else begin
              kind = (kind_held_next != put_code);
              kind_held_next = {7'd0, kind};
              res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_START, '0, kind, key_left_next,
                                             kind ? 32'd0 : value_left_next, '0, '0, '0, '0);
              nres = nres + 2'd1;
              if (key_left_next != 32'd0) phase_next = PH_KEY;
              else if (value_left_next != 32'd0) phase_next = PH_VAL;
              else entry_end = 1'b1;
            end
          end
        end
        PH_KEY: begin
          res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_KEY, '0, 1'b0, '0, '0, b, '0, '0, '0);
          nres = nres + 2'd1;
          key_left_next = key_left - 32'd1;
          if (key_left_next == 32'd0) begin
            if (value_left != 32'd0) phase_next = PH_VAL;
            else entry_end = 1'b1;
          end
        end
        PH_VAL: begin
          if (kind_held == 8'd0) begin
            res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_VAL, '0, 1'b0, '0, '0, b, '0, '0, '0);
            nres = nres + 2'd1;
          end
          value_left_next = value_left - 32'd1;
          if (value_left_next == 32'd0) entry_end = 1'b1;
        end
        default: begin
        end
      endcase
      if (entry_end) begin
        entries_left_next = entries_left - 32'd1;
        fbc_next = '0;
        phase_next = (entries_left_next != 32'd0) ? PH_ENTHDR : PH_TAIL;
      end
      vdo = (payload_left_next == 32'd0);
    end

    if (vdo) begin
      ev_err_v = err_held_next;
      ev_err = err_code_next;
      if (!ev_err_v) begin
        if (phase_next == PH_BATCH) begin
          ev_err_v = 1'b1;
          ev_err = lrd_pkg::ERR_BATCH_HEADER;
        end else if (phase_next == PH_ENTHDR) begin
          ev_err_v = 1'b1;
          ev_err = (fbc_next != 4'd0) ? lrd_pkg::ERR_ENTRY_HEADER : lrd_pkg::ERR_TRUNC_ENTRY;
        end
      end
      fbc_next = '0;
      if (record_kind_next != lrd_pkg::BATCH_RECORD_TYPE) begin
        res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_CORRUPT, lrd_pkg::ERR_RECORD_TYPE, 1'b0,
                                       '0, '0, '0, '0, '0, committed_next);
        nres = nres + 2'd1;
        phase_next = PH_DROP;
        ended = 1'b1;
      end else if (~running_crc_next != stored_crc_next) begin
        if (last) begin
          res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_END, '0, 1'b0, '0, '0, '0, '0, '0,
                                         committed_next);
          phase_next = PH_HDR;
        end else begin
          res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_CORRUPT, lrd_pkg::ERR_CHECKSUM, 1'b0,
                                         '0, '0, '0, '0, '0, committed_next);
          phase_next = PH_DROP;
        end
        nres = nres + 2'd1;
        ended = 1'b1;
      end else if (ev_err_v) begin
        res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_CORRUPT, ev_err, 1'b0, '0, '0, '0, '0,
                                       '0, committed_next);
        nres = nres + 2'd1;
        phase_next = PH_DROP;
        ended = 1'b1;
      end else begin
        committed_next = position_next;
        res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_ACCEPT, '0, 1'b0, '0, '0, '0,
                                       sequence_base_next, entries_total_next, committed_next);
        nres = nres + 2'd1;
        if (last) begin
          res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_END, '0, 1'b0, '0, '0, '0, '0, '0,
                                         committed_next);
          nres = nres + 2'd1;
        end
        phase_next = PH_HDR;
        ended = last;
      end
    end

    if (last) begin
      if (!ended) begin
        res[nres] = lrd_pkg::mk_result(lrd_pkg::EV_END, '0, 1'b0, '0, '0, '0, '0, '0,
                                       committed_next);
        nres = nres + 2'd1;
      end
      phase_next = PH_HDR;
      fbc_next = '0;
      position_next = '0;
      committed_next = '0;
    end

    if (nres != 2'd0) begin
      res[nres - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      put_code <= 8'd0;
      delete_code <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        lrd_pkg::REG_PUT_CODE: put_code <= cfg_data;
        lrd_pkg::REG_DELETE_CODE: delete_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;
      fbc <= '0;
      stored_crc <= '0;
      record_kind <= '0;
      payload_left <= '0;
      running_crc <= lrd_pkg::CRC_INIT;
      sequence_base <= '0;
      entries_total <= '0;
      entries_left <= '0;
      kind_held <= '0;
      key_left <= '0;
      value_left <= '0;
      err_held <= 1'b0;
      err_code <= '0;
      position <= '0;
      committed <= '0;
    end else if (in_acc) begin
      phase <= phase_next;
      fbc <= fbc_next;
      stored_crc <= stored_crc_next;
      record_kind <= record_kind_next;
      payload_left <= payload_left_next;
      running_crc <= running_crc_next;
      sequence_base <= sequence_base_next;
      entries_total <= entries_total_next;
      entries_left <= entries_left_next;
      kind_held <= kind_held_next;
      key_left <= key_left_next;
      value_left <= value_left_next;
      err_held <= err_held_next;
      err_code <= err_code_next;
      position <= position_next;
      committed <= committed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < nres) fifo[wr_ptr + 2'(k)] <= res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + (in_acc ? nres : 2'd0);
      rd_ptr <= rd_ptr + {1'b0, out_acc};
      count <= count + (in_acc ? {1'b0, nres} : 3'd0) - {2'd0, out_acc};
    end
  end

  assign m_axis_tuser = fifo[rd_ptr].event_res;
  assign m_axis_tlast = fifo[rd_ptr].last_of_run;
  assign m_axis_tdata = {
    {(lrd_pkg::TDATA_BITS - lrd_pkg::TDATA_FIELD_BITS){1'b0}},
    fifo[rd_ptr].valid_bytes,
    fifo[rd_ptr].entry_count,
    fifo[rd_ptr].base_sequence,
    fifo[rd_ptr].byte_value,
    fifo[rd_ptr].value_length,
    fifo[rd_ptr].key_length,
    fifo[rd_ptr].entry_kind,
    fifo[rd_ptr].error_code
  };

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(lrd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (in_acc && phase == PH_DROP && !s_axis_tlast) |=> count <= $past(count))
    else $error("event produced while dropping bytes");

  a_log_end_restart: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tlast) |=> (phase == PH_HDR && position == '0 && committed == '0))
    else $error("log end did not restart parsing");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (phase == PH_HDR && count == 3'd0))
    else $error("reset did not clear state");

endmodule

// File: verif/log_record_decoder_checker.sv
`timescale 1ns / 1ps

package lrd_tb_pkg;

  function automatic logic [31:0] crc32c_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ lrd_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module log_record_decoder_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [lrd_pkg::TDATA_BITS-1:0] m_axis_tdata,
  input  logic [2:0]                     m_axis_tuser,
  input  logic                           m_axis_tlast,
  output int                             errors,
  output int                             pending
);

  typedef enum logic [2:0] {
    ST_HEADER, ST_BATCH, ST_ENTRY_HDR, ST_KEY, ST_VALUE, ST_TAIL, ST_DROP
  } parse_state_t;

  localparam logic [3:0] NO_ERROR = 4'd15;
  localparam logic [lrd_pkg::OFFSET_BITS-1:0] POS_MAX = '1;

  lrd_pkg::result_t events_due[$];
  lrd_pkg::result_t byte_events[$];

  logic [7:0] put_code, delete_code;
  parse_state_t state;
  int unsigned field_idx;
  logic [31:0] hdr_crc, rec_len, pay_left, crc_acc, batch_count, entries_left;
  logic [31:0] key_left, val_left;
  logic [7:0] rec_type, kind_byte;
  logic [63:0] batch_seq;
  logic [3:0] held_err;
  logic [lrd_pkg::OFFSET_BITS-1:0] position, committed;

  function automatic lrd_pkg::result_t make_event(input logic [2:0] ev,
                                                  input logic [2:0] err,
                                                  input logic kind, input logic [31:0] klen,
                                                  input logic [31:0] vlen,
                                                  input logic [7:0] bval,
                                                  input logic [63:0] seq,
                                                  input logic [31:0] cnt,
                                                  input logic [lrd_pkg::OFFSET_BITS-1:0] vb);
    lrd_pkg::result_t r;
    r = '0;
    r.event_res = ev;
    r.error_code = err;
    r.entry_kind = kind;
    r.key_length = klen;
    r.value_length = vlen;
    r.byte_value = bval;
    r.base_sequence = seq;
    r.entry_count = cnt;
    r.valid_bytes = vb;
    return r;
  endfunction

  task automatic push_event(input lrd_pkg::result_t r);
    if (byte_events.size() < 3) byte_events.insert(byte_events.size(), r);
  endtask

  task automatic parser_reset();
    put_code = 8'd0;
    delete_code = 8'd1;
    state = ST_HEADER;
    field_idx = 0;
    hdr_crc = '0;
    rec_len = '0;
    rec_type = '0;
    pay_left = '0;
    crc_acc = lrd_pkg::CRC_INIT;
    batch_seq = '0;
    batch_count = '0;
    entries_left = '0;
    kind_byte = '0;
    key_left = '0;
    val_left = '0;
    held_err = NO_ERROR;
    position = '0;
    committed = '0;
  endtask

  task automatic finish_entry();
    entries_left = entries_left - 32'd1;
    field_idx = 0;
    state = (entries_left != 0) ? ST_ENTRY_HDR : ST_TAIL;
  endtask

  task automatic judge_record(input bit last, output bit ended);
    logic [3:0] err;
    err = held_err;
    if (err == NO_ERROR) begin
      if (state == ST_BATCH) err = {1'b0, lrd_pkg::ERR_BATCH_HEADER};
      else if (state == ST_ENTRY_HDR)
        err = (field_idx != 0) ? {1'b0, lrd_pkg::ERR_ENTRY_HEADER}
                               : {1'b0, lrd_pkg::ERR_TRUNC_ENTRY};
    end
    field_idx = 0;
    ended = 1'b1;
    if (rec_type != lrd_pkg::BATCH_RECORD_TYPE) begin
      push_event(make_event(lrd_pkg::EV_CORRUPT, lrd_pkg::ERR_RECORD_TYPE, 1'b0, '0, '0, '0,
                            '0, '0, committed));
      state = ST_DROP;
    end else if (~crc_acc != hdr_crc) begin
      if (last) begin
        push_event(make_event(lrd_pkg::EV_END, '0, 1'b0, '0, '0, '0, '0, '0, committed));
        state = ST_HEADER;
      end else begin
        push_event(make_event(lrd_pkg::EV_CORRUPT, lrd_pkg::ERR_CHECKSUM, 1'b0, '0, '0, '0,
                              '0, '0, committed));
        state = ST_DROP;
      end
    end else if (err != NO_ERROR) begin
      push_event(make_event(lrd_pkg::EV_CORRUPT, err[2:0], 1'b0, '0, '0, '0, '0, '0,
                            committed));
      state = ST_DROP;
    end else begin
      committed = position;
      push_event(make_event(lrd_pkg::EV_ACCEPT, '0, 1'b0, '0, '0, '0, batch_seq, batch_count,
                            committed));
      if (last)
        push_event(make_event(lrd_pkg::EV_END, '0, 1'b0, '0, '0, '0, '0, '0, committed));
      state = ST_HEADER;
      ended = last;
    end
  endtask

  task automatic take_payload_byte(input logic [7:0] b);
    int unsigned i;
    logic kind;
    i = field_idx;
    crc_acc = lrd_tb_pkg::crc32c_next(crc_acc, b);
    pay_left = pay_left - 32'd1;
    case (state)
      ST_BATCH: begin
        if (i < 8) batch_seq[8*i +: 8] = b;
        else batch_count[8*(i-8) +: 8] = b;
        field_idx = i + 1;
        if (field_idx >= lrd_pkg::BATCH_HEADER_BYTES) begin
          field_idx = 0;
          entries_left = batch_count;
          state = (entries_left != 0) ? ST_ENTRY_HDR : ST_TAIL;
        end
      end
      ST_ENTRY_HDR: begin
        if (i == 0) begin
          kind_byte = b;
          key_left = '0;
          val_left = '0;
        end else if (i < 5) begin
          key_left[8*(i-1) +: 8] = b;
        end else begin
          val_left[8*(i-5) +: 8] = b;
        end
        field_idx = i + 1;
        if (field_idx >= lrd_pkg::ENTRY_HEADER_BYTES) begin
          field_idx = 0;
          if ({1'b0, key_left} + {1'b0, val_left} > {1'b0, pay_left}) begin
            held_err = {1'b0, lrd_pkg::ERR_TRUNC_PAYLOAD};
            state = ST_TAIL;
          end else if (kind_byte != put_code && kind_byte != delete_code) begin
            held_err = {1'b0, lrd_pkg::ERR_ENTRY_TYPE};
            state = ST_TAIL;
          end else begin
            kind = (kind_byte != put_code);
            kind_byte = {7'd0, kind};
            push_event(make_event(lrd_pkg::EV_START, '0, kind, key_left,
                                  kind ? 32'd0 : val_left, '0, '0, '0, '0));
            if (key_left != 0) state = ST_KEY;
            else if (val_left != 0) state = ST_VALUE;
            else finish_entry();
          end
        end
      end
      ST_KEY: begin
        push_event(make_event(lrd_pkg::EV_KEY, '0, 1'b0, '0, '0, b, '0, '0, '0));
        key_left = key_left - 32'd1;
        if (key_left == 0) begin
          if (val_left != 0) state = ST_VALUE;
          else finish_entry();
        end
      end
      ST_VALUE: begin
        if (kind_byte == 0)
          push_event(make_event(lrd_pkg::EV_VAL, '0, 1'b0, '0, '0, b, '0, '0, '0));
        val_left = val_left - 32'd1;
        if (val_left == 0) finish_entry();
      end
      default: ;
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input bit last);
    bit ended;
    ended = 1'b0;
    byte_events.delete();
    if (position < POS_MAX) position = position + 1'b1;
    if (state == ST_DROP) begin
      ended = 1'b1;
    end else if (state == ST_HEADER) begin
      if (field_idx == 0) begin
        hdr_crc = '0;
        rec_len = '0;
        rec_type = '0;
      end
      if (field_idx < 4) hdr_crc[8*field_idx +: 8] = b;
      else if (field_idx < 8) rec_len[8*(field_idx-4) +: 8] = b;
      else rec_type = b;
      field_idx = field_idx + 1;
      if (field_idx >= lrd_pkg::HEADER_BYTES) begin
        field_idx = 0;
        pay_left = rec_len;
        crc_acc = lrd_pkg::CRC_INIT;
        batch_seq = '0;
        batch_count = '0;
        entries_left = '0;
        held_err = NO_ERROR;
        state = ST_BATCH;
        if (pay_left == 0) judge_record(last, ended);
      end
    end else begin
      take_payload_byte(b);
      if (pay_left == 0) judge_record(last, ended);
    end
    if (last) begin
      if (!ended)
        push_event(make_event(lrd_pkg::EV_END, '0, 1'b0, '0, '0, '0, '0, '0, committed));
      state = ST_HEADER;
      field_idx = 0;
      position = '0;
      committed = '0;
    end
    if (byte_events.size() > 0) byte_events[byte_events.size()-1].last_of_run = 1'b1;
    foreach (byte_events[k]) events_due.insert(events_due.size(), byte_events[k]);
  endtask

  always @(posedge clk) begin
    lrd_pkg::result_t seen;
    lrd_pkg::result_t want;
    if (rst) begin
      parser_reset();
      events_due.delete();
      errors <= 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lrd_pkg::REG_PUT_CODE) put_code = cfg_data;
        else delete_code = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.event_res = m_axis_tuser;
        seen.error_code = m_axis_tdata[2:0];
        seen.entry_kind = m_axis_tdata[3];
        seen.key_length = m_axis_tdata[35:4];
        seen.value_length = m_axis_tdata[67:36];
        seen.byte_value = m_axis_tdata[75:68];
        seen.base_sequence = m_axis_tdata[139:76];
        seen.entry_count = m_axis_tdata[171:140];
        seen.valid_bytes = m_axis_tdata[172 +: lrd_pkg::OFFSET_BITS];
        seen.last_of_run = m_axis_tlast;
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %p", $time, seen);
          errors <= errors + 1;
        end else begin
          want = events_due.pop_front();
          if (seen !== want) begin
            $display("%0t: event mismatch, expected %p, actual %p", $time, want, seen);
            errors <= errors + 1;
          end
        end
      end
      pending = events_due.size();
    end
  end

endmodule

// File: verif/log_record_decoder_top_tb.sv
`timescale 1ns / 1ps

module log_record_decoder_top_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [lrd_pkg::TDATA_BITS-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = lrd_pkg::REG_PUT_CODE;
  logic [7:0] cfg_data = '0;
  int errors;
  int pending;

  int send_idle_pct;
  int recv_stall_pct;
  int unsigned cycles = 0;
  int unsigned bytes_sent;
  logic [7:0] put_now, del_now;
  logic [7:0] log_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  log_record_decoder_top dut (.*);

  log_record_decoder_checker checker_i (.*);

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == lrd_pkg::REG_PUT_CODE) put_now = value;
    else del_now = value;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0 || m_axis_tvalid);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Flavors: 0 good, 1 wrong record type, 2 bad checksum, 3 empty payload,
  // 4 unknown entry kind, 5 entry longer than payload, 6 good with trailing bytes,
  // 7 payload cut inside the batch header, 8 payload cut inside the entries.
  task automatic add_record(input int flavor);
    logic [7:0] pl[$];
    logic [63:0] seq;
    logic [31:0] klen, vlen, crc;
    logic [7:0] kb, rtype;
    int n, cut;
    seq = {$urandom, $urandom};
    n = (flavor inside {4, 5, 8}) ? $urandom_range(1, 3) : $urandom_range(0, 3);
    if (flavor != 3) begin
      for (int i = 0; i < 8; i++) pl.insert(pl.size(), seq[8*i +: 8]);
      for (int i = 0; i < 4; i++) pl.insert(pl.size(), 8'(n >> (8*i)));
      for (int e = 0; e < n; e++) begin
        if (flavor == 4 && e == n - 1) begin
          do kb = 8'($urandom); while (kb == put_now || kb == del_now);
        end else begin
          kb = ($urandom_range(2) == 1) ? del_now : put_now;
        end
        klen = $urandom_range(0, 3);
        vlen = $urandom_range(0, 3);
        if (flavor == 5 && e == n - 1) begin
          klen = $urandom;
          vlen = $urandom | 32'h0100_0000;
        end
        pl.insert(pl.size(), kb);
        for (int i = 0; i < 4; i++) pl.insert(pl.size(), klen[8*i +: 8]);
        for (int i = 0; i < 4; i++) pl.insert(pl.size(), vlen[8*i +: 8]);
        if (!(flavor == 5 && e == n - 1))
          for (int i = 0; i < klen + vlen; i++) pl.insert(pl.size(), 8'($urandom));
      end
      if (flavor == 6) repeat ($urandom_range(1, 3)) pl.insert(pl.size(), 8'($urandom));
      if (flavor == 5) repeat ($urandom_range(0, 4)) pl.insert(pl.size(), 8'($urandom));
      cut = pl.size();
      if (flavor == 7) cut = $urandom_range(1, 11);
      if (flavor == 8) cut = 12 + $urandom_range(0, 8);
      while (pl.size() > cut) void'(pl.pop_back());
    end
    crc = lrd_pkg::CRC_INIT;
    foreach (pl[i]) crc = lrd_tb_pkg::crc32c_next(crc, pl[i]);
    crc = ~crc;
    if (flavor == 2) crc[$urandom_range(31)] ^= 1'b1;
    rtype = lrd_pkg::BATCH_RECORD_TYPE;
    if (flavor == 1) do rtype = 8'($urandom); while (rtype == lrd_pkg::BATCH_RECORD_TYPE);
    for (int i = 0; i < 4; i++) log_q.insert(log_q.size(), crc[8*i +: 8]);
    for (int i = 0; i < 4; i++) log_q.insert(log_q.size(), 8'(pl.size() >> (8*i)));
    log_q.insert(log_q.size(), rtype);
    foreach (pl[i]) log_q.insert(log_q.size(), pl[i]);
  endtask

  task automatic send_log();
    foreach (log_q[i]) send_byte(log_q[i], i == log_q.size() - 1);
    log_q.delete();
  endtask

  task automatic random_log();
    int pick;
    repeat ($urandom_range(1, 2)) begin
      pick = $urandom_range(0, 15);
      add_record(pick < 6 ? 0 : (pick < 8 ? 6 : pick - 7));
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) if (log_q.size() > 1) void'(log_q.pop_back());
    end
    send_log();
  endtask

  initial begin
    put_now = 8'd0;
    del_now = 8'd1;
    bytes_sent = 0;
    send_idle_pct = 17;
    recv_stall_pct = 77;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_record(0);
    while (log_q.size() > 5) void'(log_q.pop_back());
    send_log();
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);

    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(lrd_pkg::REG_PUT_CODE, 8'hff);
          write_reg(lrd_pkg::REG_DELETE_CODE, 8'h00);
        end
        1: begin
          send_idle_pct = 77;
          recv_stall_pct = 17;
          write_reg(lrd_pkg::REG_PUT_CODE, 8'h5a);
          write_reg(lrd_pkg::REG_DELETE_CODE, 8'h5a);
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_reg(lrd_pkg::REG_PUT_CODE, 8'h00);
          write_reg(lrd_pkg::REG_DELETE_CODE, 8'hff);
        end
      endcase
      cfg_we <= 1'b0;
      bytes_sent = 0;
      while (bytes_sent < 50) random_log();
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
